/* hw/rtl/snfas_pkg.sv */
`timescale 1ns / 1ps

package snfas_pkg;

   localparam int ADDR_W  = 24;
   localparam int LEN_W   = 25;
   localparam int COUNT_W = 13;
   localparam int SUM_W   = LEN_W + 1;

   localparam int FLASH_BYTES      = 16 * 1024 * 1024;
   localparam int PAGE_BYTES       = 256;
   localparam int SECTOR_BYTES     = 4096;
   localparam int READ_CHUNK_BYTES = 4096;

   localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
   localparam int SECTOR_BITS = $clog2(SECTOR_BYTES);

   localparam logic [7:0] OP_READ    = 8'h03;
   localparam logic [7:0] OP_PROGRAM = 8'h02;
   localparam logic [7:0] OP_ERASE   = 8'h20;
   localparam logic [7:0] OP_WREN    = 8'h06;

   typedef enum logic [1:0] {
      FUNC_READ    = 2'd0,
      FUNC_PROGRAM = 2'd1,
      FUNC_ERASE   = 2'd2,
      FUNC_ADVANCE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_REJECTED    = 3'd1,
      STAT_READ_FAIL   = 3'd2,
      STAT_PROG_FAIL   = 3'd3,
      STAT_ERASE_FAIL  = 3'd4,
      STAT_NONE_ACTIVE = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_READ    = 4'b0010,
      MODE_PROGRAM = 4'b0100,
      MODE_ERASE   = 4'b1000
   } mode_type;

   typedef struct packed {
      func_type            func;
      logic [ADDR_W-1:0]   start_address;
      logic [LEN_W-1:0]    byte_length;
      logic                frame_ok;
   } req_item_type;

   typedef struct packed {
      logic                frame_valid;
      logic [7:0]          opcode;
      logic [ADDR_W-1:0]   frame_address;
      logic [COUNT_W-1:0]  data_count;
      logic                needs_write_enable;
      logic                needs_ready_wait;
      logic                finished;
      status_type          status;
   } rsp_item_type;

endpackage

/* hw/rtl/snfas_in_stage.sv */
`timescale 1ns / 1ps

module snfas_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  snfas_pkg::req_item_type req_item,
   output logic                  item_valid,
   output snfas_pkg::req_item_type item,
   input  logic                  item_take
);
   import snfas_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         accept;

   // hold the item until the core consumes it
   assign req_stall = valid_ff & ~item_take;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hw/rtl/snfas_core.sv */
`timescale 1ns / 1ps

module snfas_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic                    csr_device_ready,
   input  logic                    item_valid,
   input  snfas_pkg::req_item_type item,
   output logic                    item_take,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output snfas_pkg::rsp_item_type rsp_item
);
   import snfas_pkg::*;

   localparam logic [LEN_W-1:0] SECTOR_MASK = LEN_W'(SECTOR_BYTES - 1);

   logic             device_ready_ff;
   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] next_addr_ff, next_addr_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic             is_start;
   mode_type         start_mode;
   logic [SUM_W-1:0] start_end;
   logic [SUM_W-1:0] erase_last;
   logic             out_of_range;
   mode_type         base_mode;
   logic [LEN_W-1:0] base_addr;
   logic [LEN_W-1:0] base_remain;
   logic [COUNT_W-1:0] page_room;
   logic [COUNT_W-1:0] frame_count;
   logic [LEN_W-1:0] frame_next;
   logic [LEN_W-1:0] frame_remain;
   logic             req_done;
   rsp_item_type     frame_rsp;
   rsp_item_type     empty_rsp;

   assign item_take = item_valid & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      case (item.func)
         FUNC_READ:    start_mode = MODE_READ;
         FUNC_PROGRAM: start_mode = MODE_PROGRAM;
         FUNC_ERASE:   start_mode = MODE_ERASE;
         default:      start_mode = MODE_IDLE;
      endcase
   end

   assign is_start     = (item.func != FUNC_ADVANCE);
   assign start_end    = SUM_W'(item.start_address) + SUM_W'(item.byte_length);
   assign erase_last   = start_end + SUM_W'(SECTOR_BYTES - 1);
   assign out_of_range = (start_end > SUM_W'(FLASH_BYTES));

   // frame source: fresh request or stored progress
   always_comb begin
      if (is_start) begin
         base_mode = start_mode;
         if (start_mode == MODE_ERASE) begin
            base_addr   = LEN_W'(item.start_address) & ~SECTOR_MASK;
            base_remain = erase_last[LEN_W-1:0] & ~SECTOR_MASK;
         end else begin
            base_addr   = LEN_W'(item.start_address);
            base_remain = item.byte_length;
         end
      end else begin
         base_mode   = mode_ff;
         base_addr   = next_addr_ff;
         base_remain = remain_ff;
      end
   end

   assign page_room = COUNT_W'(PAGE_BYTES) - COUNT_W'(base_addr[PAGE_BITS-1:0]);

   always_comb begin
      frame_count = '0;
      frame_rsp   = '0;
      case (base_mode)
         MODE_READ: begin
            if (base_remain > LEN_W'(READ_CHUNK_BYTES)) begin
               frame_count = COUNT_W'(READ_CHUNK_BYTES);
            end else begin
               frame_count = base_remain[COUNT_W-1:0];
            end
            frame_rsp.opcode = OP_READ;
         end
         MODE_PROGRAM: begin
            if (base_remain > LEN_W'(page_room)) begin
               frame_count = page_room;
            end else begin
               frame_count = base_remain[COUNT_W-1:0];
            end
            frame_rsp.opcode             = OP_PROGRAM;
            frame_rsp.needs_write_enable = 1'b1;
            frame_rsp.needs_ready_wait   = 1'b1;
         end
         default: begin
            frame_rsp.opcode             = OP_ERASE;
            frame_rsp.needs_write_enable = 1'b1;
            frame_rsp.needs_ready_wait   = 1'b1;
         end
      endcase
      frame_rsp.frame_valid   = 1'b1;
      frame_rsp.frame_address = base_addr[ADDR_W-1:0];
      frame_rsp.data_count    = frame_count;
      frame_rsp.finished      = 1'b0;
      frame_rsp.status        = STAT_OK;
   end

   always_comb begin
      if (base_mode == MODE_ERASE) begin
         frame_next   = base_addr + LEN_W'(SECTOR_BYTES);
         frame_remain = base_remain;
      end else begin
         frame_next   = base_addr + LEN_W'(frame_count);
         frame_remain = base_remain - LEN_W'(frame_count);
      end
   end

   // erase ends on the aligned end address, others on a zero byte count
   assign req_done = (mode_ff == MODE_ERASE) ? (next_addr_ff >= remain_ff)
                                             : (remain_ff == '0);

   always_comb begin
      empty_rsp        = '0;
      empty_rsp.status = STAT_OK;
      mode_in          = mode_ff;
      next_addr_in     = next_addr_ff;
      remain_in        = remain_ff;
      rsp_in           = empty_rsp;
      if (!is_start) begin
         if (mode_ff == MODE_IDLE) begin
            rsp_in.status = STAT_NONE_ACTIVE;
         end else if (!item.frame_ok) begin
            mode_in         = MODE_IDLE;
            rsp_in.finished = 1'b1;
            case (mode_ff)
               MODE_READ:    rsp_in.status = STAT_READ_FAIL;
               MODE_PROGRAM: rsp_in.status = STAT_PROG_FAIL;
               default:      rsp_in.status = STAT_ERASE_FAIL;
            endcase
         end else if (req_done) begin
            mode_in         = MODE_IDLE;
            rsp_in.finished = 1'b1;
         end else begin
            rsp_in       = frame_rsp;
            next_addr_in = frame_next;
            remain_in    = frame_remain;
         end
      end else begin
         mode_in = MODE_IDLE;
         if (!device_ready_ff || out_of_range) begin
            rsp_in.finished = 1'b1;
            rsp_in.status   = STAT_REJECTED;
         end else if (item.byte_length == '0) begin
            rsp_in.finished = 1'b1;
         end else begin
            mode_in      = start_mode;
            rsp_in       = frame_rsp;
            next_addr_in = frame_next;
            remain_in    = frame_remain;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_ready_ff <= 1'b0;
         mode_ff         <= MODE_IDLE;
         next_addr_ff    <= '0;
         remain_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            device_ready_ff <= csr_device_ready;
         end
         if (item_take) begin
            mode_ff      <= mode_in;
            next_addr_ff <= next_addr_in;
            remain_ff    <= remain_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_frame_not_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_valid |-> !rsp_ff.finished && rsp_ff.status == STAT_OK)
      else $error("frame issued together with completion");

   a_read_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_valid && rsp_ff.opcode == OP_READ
      |-> rsp_ff.data_count != '0 && rsp_ff.data_count <= COUNT_W'(READ_CHUNK_BYTES))
      else $error("read chunk size out of range");

   a_page_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_valid && rsp_ff.opcode == OP_PROGRAM
      |-> (COUNT_W'(rsp_ff.frame_address[PAGE_BITS-1:0]) + rsp_ff.data_count)
          <= COUNT_W'(PAGE_BYTES) && rsp_ff.data_count != '0)
      else $error("program frame crosses a page");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      item_take && rsp_in.finished |=> mode_ff == MODE_IDLE)
      else $error("request finished but still active");

   a_idle_no_frame: assert property (@(posedge clock) disable iff (reset)
      item_take && !is_start && mode_ff == MODE_IDLE |=> !rsp_ff.frame_valid)
      else $error("frame issued while nothing active");

endmodule

/* hw/rtl/spi_nor_flash_access_sequencer.sv */
`timescale 1ns / 1ps

// serial nor flash command sequencer
// req_ channel: one transaction per item. func selects start read, start program,
//   start erase or advance; a start carries req_start_address/req_byte_length, an
//   advance carries req_frame_ok for the frame issued last
// rsp_ channel: exactly one transaction per request transaction, in order. a frame
//   descriptor (opcode, address, data count, write enable / ready wait flags) or a
//   completion with status; finished marks the last transaction of a request
// csr_ channel: writes device_ready; csr_ready is always high, write only when idle
// path: an accepted req item passes the input register, then the single-pass frame
//   logic into the result register, which drives rsp_valid
// throughput: one transaction per cycle unless rsp stalls; stored address/remaining
//   state updates in the same cycle the result register loads, so items chain freely
// reset: synchronous, clears device_ready, active request and both valid flags
// when the receiver stalls rsp, the result register holds, the input register fills,
//   and then req_stall rises; nothing is dropped
module spi_nor_flash_access_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [23:0] req_start_address,
   input  logic [24:0] req_byte_length,
   input  logic        req_frame_ok,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_valid,
   output logic [7:0]  rsp_opcode,
   output logic [23:0] rsp_frame_address,
   output logic [12:0] rsp_data_count,
   output logic        rsp_needs_write_enable,
   output logic        rsp_needs_ready_wait,
   output logic        rsp_finished,
   output logic [2:0]  rsp_status,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_device_ready
);
   import snfas_pkg::*;

   req_item_type req_item;
   req_item_type stage_item;
   logic         stage_valid;
   logic         stage_take;
   rsp_item_type rsp_item;

   // pack the request transaction
   assign req_item.func          = func_type'(req_func);
   assign req_item.start_address = req_start_address;
   assign req_item.byte_length   = req_byte_length;
   assign req_item.frame_ok      = req_frame_ok;

   // configuration always taken at once
   assign csr_ready = 1'b1;

   snfas_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .item_valid (stage_valid),
      .item       (stage_item),
      .item_take  (stage_take)
   );

   // frame splitting, state update and result register
   snfas_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_device_ready (csr_device_ready),
      .item_valid       (stage_valid),
      .item             (stage_item),
      .item_take        (stage_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item)
   );

   // unpack the result transaction
   assign rsp_frame_valid        = rsp_item.frame_valid;
   assign rsp_opcode             = rsp_item.opcode;
   assign rsp_frame_address      = rsp_item.frame_address;
   assign rsp_data_count         = rsp_item.data_count;
   assign rsp_needs_write_enable = rsp_item.needs_write_enable;
   assign rsp_needs_ready_wait   = rsp_item.needs_ready_wait;
   assign rsp_finished           = rsp_item.finished;
   assign rsp_status             = rsp_item.status;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// checks the serial nor flash command sequencer against an in-bench model of
// its frame splitting: read chunks, program pages, erase sectors, failures
module tb;
   import snfas_pkg::*;

   localparam int RUN_LIMIT = 200000;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request channel
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_ADVANCE;
   logic [ADDR_W-1:0]  req_start_address = '0;
   logic [LEN_W-1:0]   req_byte_length = '0;
   logic               req_frame_ok = 1'b0;

   // result channel
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_frame_valid;
   logic [7:0]         rsp_opcode;
   logic [ADDR_W-1:0]  rsp_frame_address;
   logic [COUNT_W-1:0] rsp_data_count;
   logic               rsp_needs_write_enable;
   logic               rsp_needs_ready_wait;
   logic               rsp_finished;
   logic [2:0]         rsp_status;

   // register write channel
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_device_ready = 1'b0;

   spi_nor_flash_access_sequencer u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_start_address      (req_start_address),
      .req_byte_length        (req_byte_length),
      .req_frame_ok           (req_frame_ok),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_frame_valid        (rsp_frame_valid),
      .rsp_opcode             (rsp_opcode),
      .rsp_frame_address      (rsp_frame_address),
      .rsp_data_count         (rsp_data_count),
      .rsp_needs_write_enable (rsp_needs_write_enable),
      .rsp_needs_ready_wait   (rsp_needs_ready_wait),
      .rsp_finished           (rsp_finished),
      .rsp_status             (rsp_status),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_device_ready       (csr_device_ready)
   );

   // sequencer model state, mirrors the block after each accepted transaction
   logic             model_device_ready = 1'b0;
   mode_type         model_mode = MODE_IDLE;
   logic [LEN_W-1:0] model_next_addr = '0;
   logic [LEN_W-1:0] model_left_or_end = '0;   // bytes left, or erase end address

   rsp_item_type descriptor_queue[$];

   // idle percentages and the long receiver hold-off
   int unsigned req_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;

   // run statistics
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned starts_sent = 0;
   int unsigned frames_seen = 0;
   int unsigned completions_seen = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned cycle_count = 0;

   // next frame of the active request; updates address and bytes left
   function automatic rsp_item_type issue_frame();
      rsp_item_type r;
      logic [31:0] cnt;
      logic [31:0] page_room;
      r = '0;
      r.frame_valid = 1'b1;
      r.frame_address = model_next_addr[ADDR_W-1:0];
      case (model_mode)
         MODE_READ: begin
            cnt = 32'(model_left_or_end);
            if (cnt > READ_CHUNK_BYTES) cnt = READ_CHUNK_BYTES;
            r.opcode = OP_READ;
         end
         MODE_PROGRAM: begin
            // never cross a page boundary
            page_room = PAGE_BYTES - (32'(model_next_addr) % PAGE_BYTES);
            cnt = 32'(model_left_or_end);
            if (cnt > page_room) cnt = page_room;
            r.opcode = OP_PROGRAM;
            r.needs_write_enable = 1'b1;
            r.needs_ready_wait = 1'b1;
         end
         default: begin
            cnt = SECTOR_BYTES;
            r.opcode = OP_ERASE;
            r.needs_write_enable = 1'b1;
            r.needs_ready_wait = 1'b1;
         end
      endcase
      model_next_addr = LEN_W'(32'(model_next_addr) + cnt);
      if (model_mode != MODE_ERASE) begin
         model_left_or_end = model_left_or_end - LEN_W'(cnt);
         r.data_count = COUNT_W'(cnt);
      end
      return r;
   endfunction

   // expected result of one request transaction
   function automatic rsp_item_type predict_descriptor(input req_item_type it);
      rsp_item_type r;
      logic [31:0] span_end;
      logic [31:0] last_byte;
      logic        done;
      r = '0;
      if (it.func == FUNC_ADVANCE) begin
         if (model_mode == MODE_IDLE) begin
            r.status = STAT_NONE_ACTIVE;
            return r;
         end
         if (model_mode == MODE_ERASE) done = (model_next_addr >= model_left_or_end);
         else done = (model_left_or_end == '0);
         if (!it.frame_ok) begin
            // failed frame ends the request with a per-mode error
            r.finished = 1'b1;
            case (model_mode)
               MODE_READ:    r.status = STAT_READ_FAIL;
               MODE_PROGRAM: r.status = STAT_PROG_FAIL;
               default:      r.status = STAT_ERASE_FAIL;
            endcase
            model_mode = MODE_IDLE;
         end else if (done) begin
            r.finished = 1'b1;
            model_mode = MODE_IDLE;
         end else begin
            r = issue_frame();
         end
         return r;
      end
      // any start drops the active request silently
      model_mode = MODE_IDLE;
      span_end = 32'(it.start_address) + 32'(it.byte_length);
      if (!model_device_ready || span_end > FLASH_BYTES) begin
         r.finished = 1'b1;
         r.status = STAT_REJECTED;
         return r;
      end
      if (it.byte_length == '0) begin
         r.finished = 1'b1;
         return r;
      end
      case (it.func)
         FUNC_READ:    model_mode = MODE_READ;
         FUNC_PROGRAM: model_mode = MODE_PROGRAM;
         default:      model_mode = MODE_ERASE;
      endcase
      if (model_mode == MODE_ERASE) begin
         // whole sectors: start aligned down, end aligned up
         last_byte = span_end + SECTOR_BYTES - 1;
         model_next_addr = LEN_W'(it.start_address) & ~LEN_W'(SECTOR_BYTES - 1);
         model_left_or_end = LEN_W'(last_byte & ~32'(SECTOR_BYTES - 1));
      end else begin
         model_next_addr = LEN_W'(it.start_address);
         model_left_or_end = it.byte_length;
      end
      return issue_frame();
   endfunction

   function automatic req_item_type make_item(input func_type f, input logic [ADDR_W-1:0] a,
                                              input logic [LEN_W-1:0] n, input logic ok);
      req_item_type it;
      it.func = f;
      it.start_address = a;
      it.byte_length = n;
      it.frame_ok = ok;
      return it;
   endfunction

   // drive one request transaction, wait for acceptance, record its expected result
   task automatic send_item(input req_item_type it);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < req_gap_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_start_address <= it.start_address;
      req_byte_length <= it.byte_length;
      req_frame_ok <= it.frame_ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      descriptor_queue.push_back(predict_descriptor(it));
      items_sent++;
      if (it.func != FUNC_ADVANCE) starts_sent++;
   endtask

   // sender pauses until every outstanding result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (descriptor_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_device_ready(input logic value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_device_ready <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model_device_ready = value;
   endtask

   // random start: addresses near page and flash edges, mostly short lengths
   function automatic req_item_type random_start();
      logic [ADDR_W-1:0] a;
      logic [LEN_W-1:0]  n;
      func_type          f;
      f = func_type'($urandom_range(2));
      case ($urandom_range(3))
         0: a = ADDR_W'($urandom());
         1: a = (ADDR_W'($urandom()) & 24'hFFFF00) | ADDR_W'($urandom_range(255, 240));
         2: a = 24'hFFFFFF - ADDR_W'($urandom_range(9000));
         default: a = ADDR_W'($urandom_range(5000));
      endcase
      case ($urandom_range(19))
         0: n = '0;
         1: n = LEN_W'($urandom());
         2: n = LEN_W'(FLASH_BYTES - int'(a));
         3: n = LEN_W'(FLASH_BYTES - int'(a) + 1);
         4, 5, 6: n = LEN_W'($urandom_range(20000, 1));
         7, 8, 9, 10: n = LEN_W'($urandom_range(16, 1));
         default: n = LEN_W'($urandom_range(1200, 1));
      endcase
      return make_item(f, a, n, 1'($urandom_range(1)));
   endfunction

   // one request followed by advances until it ends, fails or gets cut off
   task automatic run_random_request();
      req_item_type it;
      int unsigned  cap;
      int unsigned  steps;
      if ($urandom_range(9) == 0) begin
         // noise: any field pattern, including advances with nothing active
         it = make_item(func_type'($urandom_range(3)), ADDR_W'($urandom()),
                        LEN_W'($urandom()), 1'($urandom_range(1)));
         send_item(it);
         return;
      end
      send_item(random_start());
      cap = $urandom_range(40, 1);
      steps = 0;
      while (model_mode != MODE_IDLE && steps < cap) begin
         it = make_item(FUNC_ADVANCE, ADDR_W'($urandom()), LEN_W'($urandom()),
                        $urandom_range(24) != 0);
         send_item(it);
         steps++;
      end
   endtask

   task automatic test_not_ready();
      // device_ready is still low after reset
      send_item(make_item(FUNC_READ, 24'h000000, 25'd16, 1'b1));
      send_item(make_item(FUNC_ERASE, 24'h001000, 25'd1, 1'b1));
      send_item(make_item(FUNC_ADVANCE, 24'hFFFFFF, 25'h1FFFFFF, 1'b1));
      write_device_ready(1'b1);
   endtask

   task automatic test_frame_splitting();
      send_item(make_item(FUNC_READ, 24'h000000, 25'd1, 1'b1));
      send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b1));
      // read one byte past a full chunk
      send_item(make_item(FUNC_READ, 24'h000010, 25'd4097, 1'b1));
      repeat (2) send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b1));
      // program straddling two page boundaries
      send_item(make_item(FUNC_PROGRAM, 24'h0000FE, 25'd300, 1'b1));
      repeat (3) send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b1));
      // erase touching two sectors
      send_item(make_item(FUNC_ERASE, 24'h000FFF, 25'd2, 1'b1));
      repeat (2) send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b1));
      // erase of the last sector, end lands on the flash size
      send_item(make_item(FUNC_ERASE, 24'hFFFFFF, 25'd1, 1'b1));
      send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b1));
   endtask

   task automatic test_request_errors();
      // one byte past the end of flash
      send_item(make_item(FUNC_PROGRAM, 24'hFFFFFF, 25'd2, 1'b1));
      send_item(make_item(FUNC_READ, 24'h123456, 25'd0, 1'b1));
      // whole flash read, then a failed frame
      send_item(make_item(FUNC_READ, 24'h000000, 25'h1000000, 1'b1));
      send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b0));
      send_item(make_item(FUNC_PROGRAM, 24'hFFFFFF, 25'd1, 1'b1));
      send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b0));
      send_item(make_item(FUNC_ERASE, 24'h000000, 25'd1, 1'b1));
      send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b0));
      // start while a read is still active
      send_item(make_item(FUNC_READ, 24'h000000, 25'd8192, 1'b1));
      send_item(make_item(FUNC_PROGRAM, 24'h000100, 25'd16, 1'b1));
      send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b1));
      send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b0));
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned gap_pct,
                                      input int unsigned stall_pct);
      int unsigned target;
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      target = items_sent + count;
      while (items_sent < target) run_random_request();
   endtask

   task automatic test_not_ready_traffic();
      write_device_ready(1'b0);
      test_random_traffic(60, 10, 10);
      write_device_ready(1'b1);
   endtask

   task automatic test_backpressure();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      // receiver holds off while a long read keeps the sender busy
      hold_request = 80;
      send_item(make_item(FUNC_READ, 24'h000000, 25'd163840, 1'b1));
      repeat (30) send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b1));
      wait_for_results();
      send_item(make_item(FUNC_ADVANCE, 24'h0, 25'd0, 1'b0));
      wait_for_results();
   endtask

   // receiver stall: random, or a long counted hold-off on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   function automatic void check_field(input string name, input longint unsigned want_v,
                                       input longint unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         error_count++;
      end
   endfunction

   // result checker: each accepted result against the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_frame_valid) frames_seen++;
         if (rsp_finished) completions_seen++;
         if (descriptor_queue.size() == 0) begin
            $error("result transaction with nothing expected");
            error_count++;
         end else begin
            want = descriptor_queue.pop_front();
            check_field("frame_valid", want.frame_valid, rsp_frame_valid);
            check_field("opcode", want.opcode, rsp_opcode);
            check_field("frame_address", want.frame_address, rsp_frame_address);
            check_field("data_count", want.data_count, rsp_data_count);
            check_field("needs_write_enable", want.needs_write_enable, rsp_needs_write_enable);
            check_field("needs_ready_wait", want.needs_ready_wait, rsp_needs_ready_wait);
            check_field("finished", want.finished, rsp_finished);
            check_field("status", want.status, rsp_status);
         end
      end
   end

   // run limit and input stall count
   always @(posedge clock) begin
      cycle_count++;
      if (req_valid && req_stall) input_stall_cycles++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_not_ready();
      test_frame_splitting();
      test_request_errors();
      test_random_traffic(700, 28, 54);
      test_not_ready_traffic();
      test_random_traffic(700, 54, 28);
      test_backpressure();
      test_random_traffic(600, 0, 0);
      wait_for_results();
      // let any late extra result show up
      repeat (10) @(posedge clock);
      $display("covered %0d request transactions (%0d starts), %0d frames, %0d completions",
               items_sent, starts_sent, frames_seen, completions_seen);
      $display("input held off for %0d cycles, %0d mismatches", input_stall_cycles,
               error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
